>>> src/csu_pkg.sv
// Shared types and constants of the containment score unit.
package csu_pkg;

    localparam int IN_W     = 16;  // Q8.8 element width
    localparam int PROD_W   = 33;  // (data - query) * query
    localparam int PACC_W   = 48;  // product accumulator, Q32.16
    localparam int QSUM_W   = 28;  // query sum, Q20.8
    localparam int SCORE_W  = 32;  // Q16.16 score
    localparam int FRAC_SH  = 8;   // Q32.16 / Q20.8 needs numerator << 8
    localparam int DIV_W    = PACC_W + FRAC_SH;
    localparam int CSU_QUEUE_DEPTH = 2;

    localparam logic signed [PACC_W-1:0] REJECT_VALUE = -48'sd655360;
    localparam logic [SCORE_W-1:0] SCORE_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic signed [IN_W-1:0] query_value;
        logic signed [IN_W-1:0] data_value;
        logic                   last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      rejected;
        logic                      zero_sum;
    } out_item_t;

    // Totals of one finished vector, handed from front to back.
    typedef struct packed {
        logic signed [PACC_W-1:0] acc;
        logic signed [QSUM_W-1:0] sum;
        logic                     rejected;
    } vec_total_t;

endpackage

>>> src/containment_score_unit_top.sv
// Containment score unit: streams element pairs, emits one score per vector.
//
// Input channel s_valid/s_ready/s_item carries one element pair per item
// (query_value, data_value, last_element). Output channel m_valid/m_ready/
// m_item carries one result per vector (score, rejected, zero_sum).
// The front end takes one element per cycle while s_ready is high: a
// registered multiply stage followed by a saturating accumulate into the
// product and query sums. On the last element the vector totals enter a
// short queue, and the back end loads them into a restoring divider that
// makes one quotient bit per cycle, then saturates the quotient into the
// output register. A zero-sum vector skips the divider and is loaded
// straight into the output register.
// Sustained rate: one element per cycle while vectors are longer than the
// divider time; shorter vectors are paced by the divider once the queue fills.
// Synchronous active-low reset clears all sums, the queue and the output.
// When the receiver stalls, the held result blocks the divider, the queue
// fills, and s_ready drops only when a last element finds the queue full.
module containment_score_unit_top import csu_pkg::*; #(
    parameter int QUEUE_DEPTH = CSU_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic       push, queue_full, q_valid, q_pop;
    vec_total_t push_data, q_data;

    csu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    csu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    csu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

>>> src/csu_front.sv
// Front end: element multiply, accumulate, reject tracking per vector.
module csu_front import csu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       push,
    output vec_total_t push_data,
    input  logic       queue_full
);

    logic                     a_vld_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic signed [IN_W-1:0]   a_q_reg;
    logic                     a_rej_reg;
    logic                     a_last_reg;

    logic signed [PACC_W-1:0] acc_reg, acc_next;
    logic signed [QSUM_W-1:0] sum_reg, sum_next;
    logic                     mark_reg, mark_next;

    logic signed [IN_W:0]     diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PACC_W:0]   acc_wide;
    logic signed [QSUM_W:0]   sum_wide;
    logic                     b_go;

    assign diff = (IN_W+1)'(s_item.data_value) - (IN_W+1)'(s_item.query_value);
    assign prod = PROD_W'(diff) * PROD_W'(s_item.query_value);

    assign b_go    = a_vld_reg && (!a_last_reg || !queue_full);
    assign s_ready = !a_vld_reg || b_go;
    assign push    = b_go && a_last_reg;

    assign acc_wide = (PACC_W+1)'(acc_reg) + (PACC_W+1)'(a_prod_reg);
    assign sum_wide = (QSUM_W+1)'(sum_reg) + (QSUM_W+1)'(a_q_reg);

    always_comb begin
        acc_next  = acc_reg;
        sum_next  = sum_reg;
        mark_next = mark_reg;
        if (!mark_reg) begin
            if (a_rej_reg) begin
                mark_next = 1'b1;
                acc_next  = REJECT_VALUE;
            end else begin
                // saturate on overflow instead of wrapping
                if (acc_wide[PACC_W] != acc_wide[PACC_W-1]) begin
                    acc_next = acc_wide[PACC_W] ? {1'b1, {(PACC_W-1){1'b0}}}
                                                : {1'b0, {(PACC_W-1){1'b1}}};
                end else begin
                    acc_next = acc_wide[PACC_W-1:0];
                end
                if (sum_wide[QSUM_W] != sum_wide[QSUM_W-1]) begin
                    sum_next = sum_wide[QSUM_W] ? {1'b1, {(QSUM_W-1){1'b0}}}
                                                : {1'b0, {(QSUM_W-1){1'b1}}};
                end else begin
                    sum_next = sum_wide[QSUM_W-1:0];
                end
            end
        end
    end

    assign push_data.acc      = acc_next;
    assign push_data.sum      = sum_next;
    assign push_data.rejected = mark_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            acc_reg   <= '0;
            sum_reg   <= '0;
            mark_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                a_vld_reg <= s_valid;
            end
            if (b_go) begin
                if (a_last_reg) begin
                    acc_reg  <= '0;
                    sum_reg  <= '0;
                    mark_reg <= 1'b0;
                end else begin
                    acc_reg  <= acc_next;
                    sum_reg  <= sum_next;
                    mark_reg <= mark_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_prod_reg <= prod;
            a_q_reg    <= s_item.query_value;
            a_rej_reg  <= s_item.query_value > s_item.data_value;
            a_last_reg <= s_item.last_element;
        end
    end

endmodule

>>> src/csu_queue.sv
// Small queue of finished vector totals between front and back.
module csu_queue import csu_pkg::*; #(
    parameter int DEPTH = CSU_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  vec_total_t push_data,
    output logic       full,
    output logic       pop_valid,
    input  logic       pop,
    output vec_total_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    vec_total_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/csu_back.sv
// Back end: bit-serial divide of accumulator by sum, saturate, output register; zero sums bypass the divide.
module csu_back import csu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_pop,
    input  vec_total_t q_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_W-1:0]    nq_reg;     // numerator shifts out, quotient shifts in
    logic [QSUM_W-1:0]   rem_reg;
    logic [QSUM_W-1:0]   den_reg;
    logic                neg_reg;
    logic                rej_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    logic                out_free;
    logic                load_out;
    logic                zero_in;
    logic [PACC_W-1:0]   acc_mag;
    logic [QSUM_W-1:0]   sum_mag;
    logic [QSUM_W:0]     rem_sh;
    logic                q_bit;
    logic [SCORE_W-1:0]  score_sat;
    logic [SCORE_W-1:0]  zero_score;

    assign out_free = !m_valid_reg || m_ready;
    assign zero_in  = q_data.sum == '0;
    // zero-sum vectors go straight to the output, so wait for a free slot
    assign q_pop    = q_valid && !busy_reg && (!zero_in || out_free);
    assign load_out = (q_pop && zero_in) || (done_reg && out_free);

    assign acc_mag = q_data.acc[PACC_W-1] ? PACC_W'(-q_data.acc) : PACC_W'(q_data.acc);
    assign sum_mag = q_data.sum[QSUM_W-1] ? QSUM_W'(-q_data.sum) : QSUM_W'(q_data.sum);

    assign rem_sh = {rem_reg, nq_reg[DIV_W-1]};
    assign q_bit  = rem_sh >= {1'b0, den_reg};

    always_comb begin
        if (neg_reg) begin
            if ((|nq_reg[DIV_W-1:SCORE_W]) || (nq_reg[SCORE_W-1] && |nq_reg[SCORE_W-2:0])) begin
                score_sat = SCORE_NEG_SAT;
            end else begin
                score_sat = -nq_reg[SCORE_W-1:0];
            end
        end else begin
            if (|nq_reg[DIV_W-1:SCORE_W-1]) begin
                score_sat = SCORE_POS_SAT;
            end else begin
                score_sat = nq_reg[SCORE_W-1:0];
            end
        end
    end

    always_comb begin
        if (q_data.acc[PACC_W-1]) begin
            zero_score = SCORE_NEG_SAT;
        end else if (q_data.acc != '0) begin
            zero_score = SCORE_POS_SAT;
        end else begin
            zero_score = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (!zero_in) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end else if (busy_reg && !done_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    done_reg <= 1'b1;
                end
            end else if (done_reg && out_free) begin
                busy_reg    <= 1'b0;
                done_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            nq_reg  <= {acc_mag, {FRAC_SH{1'b0}}};
            rem_reg <= '0;
            den_reg <= sum_mag;
            neg_reg <= q_data.acc[PACC_W-1] != q_data.sum[QSUM_W-1];
            rej_reg <= q_data.rejected;
            if (zero_in) begin
                m_item_reg.score    <= zero_score;
                m_item_reg.rejected <= q_data.rejected;
                m_item_reg.zero_sum <= 1'b1;
            end
        end else if (busy_reg && !done_reg) begin
            // restoring step: one quotient bit per cycle
            rem_reg <= q_bit ? QSUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[QSUM_W-1:0];
            nq_reg  <= {nq_reg[DIV_W-2:0], q_bit};
        end else if (done_reg && out_free) begin
            m_item_reg.score    <= score_sat;
            m_item_reg.rejected <= rej_reg;
            m_item_reg.zero_sum <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> tb/containment_score_unit_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the containment score unit: element streams in, scores out.
module containment_score_unit_top_tb;
    import csu_pkg::*;

    localparam int     STALL_LIMIT  = 5000;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     HOLD_AT      = 40;
    localparam int     SETTLE       = 100;
    localparam int     RANDOM_ITEMS = 1630;
    localparam int     Q_MIN        = -32768;
    localparam int     Q_MAX        = 32767;
    localparam longint ACC_HI = (longint'(1) <<< (PACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint SUM_HI = (longint'(1) <<< (QSUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    in_item_t  elem_backlog[$];
    out_item_t score_queue[$];
    out_item_t want;

    // Running totals of the vector in flight, at the block's widths.
    logic signed [PACC_W-1:0] acc_run = '0;
    logic signed [QSUM_W-1:0] sum_run = '0;
    logic                     rej_run = 1'b0;

    bit steady = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet = 0;
    int errors = 0;
    int elems_queued = 0;
    int elems_in = 0;
    int vectors_in = 0;
    int scores_out = 0;
    int rejects_out = 0;
    int zero_sums_out = 0;

    containment_score_unit_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Fold one accepted element into the totals; queue a score on the last one.
    function automatic void fold_element(in_item_t it);
        longint            q, d, a, s;
        longint unsigned   num, den, quo;
        logic [63:0]       score_bits;
        bit                neg;
        out_item_t         r;
        q = longint'($signed(it.query_value));
        d = longint'($signed(it.data_value));
        a = acc_run;
        s = sum_run;
        elems_in++;
        if (!rej_run) begin
            if (q > d) begin
                rej_run = 1'b1;
                a = REJECT_VALUE;
            end else begin
                a = clip(a + (d - q) * q, ACC_LO, ACC_HI);
                s = clip(s + q, SUM_LO, SUM_HI);
            end
        end
        if (it.last_element) begin
            r.rejected = rej_run;
            r.zero_sum = (s == 0);
            if (s == 0) begin
                r.score = a > 0 ? SCORE_POS_SAT : (a < 0 ? SCORE_NEG_SAT : '0);
            end else begin
                num = a < 0 ? -a : a;
                num = num << FRAC_SH;
                den = s < 0 ? -s : s;
                quo = num / den;
                neg = (a < 0) != (s < 0);
                if (neg) begin
                    if (quo > 64'h8000_0000) begin
                        quo = 64'h8000_0000;
                    end
                    score_bits = 64'd0 - quo;
                end else begin
                    if (quo > 64'h7FFF_FFFF) begin
                        quo = 64'h7FFF_FFFF;
                    end
                    score_bits = quo;
                end
                r.score = score_bits[SCORE_W-1:0];
            end
            score_queue.insert(score_queue.size(), r);
            vectors_in++;
            a = 0;
            s = 0;
            rej_run = 1'b0;
        end
        acc_run = a[PACC_W-1:0];
        sum_run = s[QSUM_W-1:0];
    endfunction

    task automatic add_elem(int q, int d, bit last);
        in_item_t it;
        it.query_value  = 16'(q);
        it.data_value   = 16'(d);
        it.last_element = last;
        elem_backlog.insert(elem_backlog.size(), it);
        elems_queued++;
    endtask

    task automatic add_run(int q, int d, int n);
        for (int i = 0; i < n; i++) begin
            add_elem(q, d, i == n - 1);
        end
    endtask

    // Mostly well-formed vectors; some carry a rejecting element, a few noise.
    task automatic add_random_vector();
        int len, cut, q, d, pick, span, scale;
        pick  = $urandom_range(99);
        len   = pick < 75 ? $urandom_range(16, 1)
              : (pick < 95 ? $urandom_range(64, 17) : $urandom_range(200, 65));
        cut   = $urandom_range(99) < 25 ? $urandom_range(len - 1, 0) : len;
        pick  = $urandom_range(99);
        scale = pick < 60 ? 0 : (pick < 88 ? 1 : 2);
        for (int i = 0; i < len; i++) begin
            if (scale == 0) begin
                q = int'($signed(16'($urandom)));
            end else if (scale == 1) begin
                q = int'($urandom_range(600, 0)) - 300;
            end else begin
                q = int'($urandom_range(4, 0)) - 2;
            end
            span = Q_MAX - q;
            if (scale != 0 && span > 600) begin
                span = 600;
            end
            if (i == cut && q > Q_MIN) begin
                d = q - int'($urandom_range(q - Q_MIN, 1));
            end else if ($urandom_range(99) < 4) begin
                d = int'($signed(16'($urandom)));
            end else begin
                d = q + int'($urandom_range(span, 0));
            end
            add_elem(q, d, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        while (elem_backlog.size() > 0 || s_valid || score_queue.size() > 0) begin
            @(negedge aclk);
        end
    endtask

    // Sender: hold the item until accepted, then advance or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fold_element(s_item);
            end
            if (!s_valid || s_ready) begin
                if (elem_backlog.size() > 0 && (steady || $urandom_range(99) >= 32)) begin
                    s_item  <= elem_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && scores_out == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || $urandom_range(99) >= 32;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            scores_out <= scores_out + 1;
            rejects_out   += m_item.rejected;
            zero_sums_out += m_item.zero_sum;
            if (score_queue.size() == 0) begin
                $error("unexpected item: score %0d rejected %0b zero_sum %0b",
                       $signed(m_item.score), m_item.rejected, m_item.zero_sum);
                errors++;
            end else begin
                want = score_queue.pop_front();
                if (m_item.score !== want.score) begin
                    $error("score: expected %0d, got %0d",
                           $signed(want.score), $signed(m_item.score));
                    errors++;
                end
                if (m_item.rejected !== want.rejected) begin
                    $error("rejected: expected %0b, got %0b", want.rejected, m_item.rejected);
                    errors++;
                end
                if (m_item.zero_sum !== want.zero_sum) begin
                    $error("zero_sum: expected %0b, got %0b", want.zero_sum, m_item.zero_sum);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("containment_score_unit_top_tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int start;
        // zero sum with zero and positive totals
        add_elem(0, 0, 1);
        add_elem(16384, Q_MAX, 0);
        add_elem(-16384, -16384, 1);
        // field extremes
        add_elem(Q_MIN, Q_MAX, 1);
        add_elem(Q_MAX, Q_MAX, 1);
        add_elem(Q_MIN, Q_MIN, 1);
        add_elem(256, 512, 1);
        add_elem(-256, 0, 1);
        // rejecting element is the last one
        add_elem(Q_MAX, Q_MIN, 1);
        // reject mid-vector; later elements must be ignored
        add_elem(256, 512, 0);
        add_elem(5, 3, 0);
        add_elem(-100, 100, 0);
        add_elem(1000, 2000, 1);
        add_elem(100, 100, 0);
        add_elem(101, 100, 1);
        // score saturates positive, then negative
        add_elem(16384, Q_MAX, 0);
        add_elem(-16384, -16384, 0);
        add_elem(1, 1, 1);
        add_elem(Q_MIN, Q_MAX, 0);
        add_elem(Q_MAX, Q_MAX, 0);
        add_elem(2, 2, 1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // Long vectors with no idling on either side.
        steady = 1'b1;
        add_run(Q_MAX, Q_MAX, 150);
        add_run(Q_MIN, Q_MAX, 150);
        wait_idle();
        steady = 1'b0;

        start = elems_queued;
        while (elems_queued - start < RANDOM_ITEMS) begin
            add_random_vector();
        end
        wait_idle();
        repeat (SETTLE) @(posedge aclk);

        $display("%0d elements in %0d vectors; %0d scores checked, %0d rejected, %0d zero-sum",
                 elems_in, vectors_in, scores_out, rejects_out, zero_sums_out);
        $display("covered field extremes, rejects, zero sums, saturated scores, a long output stall");
        if (errors == 0) begin
            $display("containment_score_unit_top_tb: PASS");
        end else begin
            $display("containment_score_unit_top_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/csu_pkg.sv
src/csu_front.sv
src/csu_queue.sv
src/csu_back.sv
src/containment_score_unit_top.sv
tb/containment_score_unit_top_tb.sv
